/* rtl/nearest_plane_ray_hit_top_defines.svh */
`ifndef NEAREST_PLANE_RAY_HIT_TOP_DEFINES_SVH
`define NEAREST_PLANE_RAY_HIT_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define NPR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define NPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/npr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package npr_pkg;

    localparam int MAX_OBJECTS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int WORDS_PER_ENTRY = 14;

    localparam logic [3:0] W_TX = 4'd9;
    localparam logic [3:0] W_TY = 4'd10;
    localparam logic [3:0] W_TZ = 4'd11;
    localparam logic [3:0] W_HW = 4'd12;
    localparam logic [3:0] W_HH = 4'd13;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RAY  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_ROT,
        S_CHK,
        S_DIV,
        S_PLANE,
        S_POINT
    } t_state;

    function automatic logic [1:0] f_mod3(input logic [3:0] v);
        logic [1:0] m;
        case (v)
            4'd0, 4'd3, 4'd6: m = 2'd0;
            4'd1, 4'd4, 4'd7: m = 2'd1;
            4'd2, 4'd5, 4'd8: m = 2'd2;
            default:          m = 2'd0;
        endcase
        return m;
    endfunction

    function automatic logic [1:0] f_div3(input logic [3:0] v);
        logic [1:0] m;
        case (v)
            4'd0, 4'd1, 4'd2: m = 2'd0;
            4'd3, 4'd4, 4'd5: m = 2'd1;
            4'd6, 4'd7, 4'd8: m = 2'd2;
            default:          m = 2'd0;
        endcase
        return m;
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [65:0] v);
        logic signed [31:0] s;
        if (v[65:31] == {35{v[31]}}) begin
            s = v[31:0];
        end else if (v[65]) begin
            s = 32'sh80000000;
        end else begin
            s = 32'sh7fffffff;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

/* rtl/nearest_plane_ray_hit_top.sv */
// Nearest ray-rectangle hit. A load transaction (operation 0) writes one word of
// one table entry and gives no result. A ray transaction (operation 1) searches
// min(object_count, MAX_OBJECTS) entries one after another and gives one result,
// on the output ports for exactly one cycle under o_valid; the receiver cannot
// stall it, so capture it then. busy stays high for the whole search. An entry
// that reaches the divider goes through these steps: its 14 words are read from
// the table, the shared 32x32 multiplier forms the rotated direction, a check
// looks for a parallel or backward entry, the bit-serial divider finds the ray
// parameter, and the in-plane test runs. A parallel or backward entry skips the
// divider and the in-plane test. The final hit point is then formed with the
// multiplier (skipped when nothing was hit) and goes to the result register; a
// ray with no entry to search gives a miss result. Write object_count only while
// busy is low.
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_plane_ray_hit_top_defines.svh"
module nearest_plane_ray_hit_top import npr_pkg::*; #(
    parameter int MAX_OBJECTS = MAX_OBJECTS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_cfg_we,
    input  wire logic [4:0]         i_cfg_data,
    input  wire logic               i_operation,
    input  wire logic [3:0]         i_object_slot,
    input  wire logic [3:0]         i_word_select,
    input  wire logic signed [31:0] i_word_value,
    input  wire logic signed [31:0] i_dir_x,
    input  wire logic signed [31:0] i_dir_y,
    input  wire logic signed [31:0] i_dir_z,
    output logic                    o_valid,
    output logic                    o_hit,
    output logic [3:0]              o_hit_object,
    output logic signed [31:0]      o_point_x,
    output logic signed [31:0]      o_point_y,
    output logic signed [31:0]      o_point_z,
    output logic [30:0]             o_hit_parameter
);

    localparam int DEPTH = MAX_OBJECTS * WORDS_PER_ENTRY;
    localparam int AW    = $clog2(DEPTH);
    localparam int OW    = $clog2(MAX_OBJECTS + 1);
    localparam int IW    = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int NW    = 32 + FRAC_BITS;

    t_state r_state, n_state;
    logic [3:0]    r_cnt, n_cnt;
    logic [AW-1:0] r_base, n_base;
    logic [OW-1:0] r_obj, n_obj;
    logic [IW-1:0] r_best, n_best;
    logic          r_found, n_found;
    logic [30:0]   r_bd, n_bd;
    logic [30:0]   r_d, n_d;
    logic signed [65:0] r_acc, n_acc;
    logic signed [64:0] r_x, n_x;
    logic [4:0]    r_objcnt;
    logic          r_valid, n_valid;
    logic          r_hit, n_hit;
    logic [3:0]    r_hobj, n_hobj;
    logic signed [31:0] r_pt [3];
    logic signed [31:0] n_pt [3];
    logic [30:0]   r_hpar, n_hpar;

    logic signed [31:0] r_w [WORDS_PER_ENTRY];
    logic signed [31:0] r_dir [3];
    logic signed [31:0] r_r [3];

    logic               w_en;
    logic               r_en;
    logic               dir_en;
    logic [1:0]         r_idx;
    logic [OW-1:0]      lim;
    logic [3:0]         km1;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic signed [63:0] p_sh;
    logic signed [65:0] acc_sum;
    logic               div_start, div_done;
    logic [NW-1:0]      div_q;
    logic [31:0]        abs_tz, abs_rz;
    logic               rz_pos, reject;
    logic signed [64:0] y_val, ax, ay;
    logic               in_rect;
    logic               more;
    logic [AW-1:0]      mem_raddr;
    logic [31:0]        mem_rdata;
    logic               load_we;
    logic [AW-1:0]      load_addr;

    assign lim = (32'(r_objcnt) > 32'(MAX_OBJECTS)) ? OW'(MAX_OBJECTS) : OW'(r_objcnt);
    assign km1 = r_cnt - 4'd1;
    assign p_sh = mul_p >>> FRAC_BITS;
    assign acc_sum = ((f_mod3(km1) == 2'd0) ? 66'sd0 : r_acc) + 66'(mul_p);

    assign rz_pos = !r_r[2][31] && (r_r[2] != 32'sd0);
    assign reject = (r_r[2] == 32'sd0) ||
                    ((r_w[W_TZ] != 32'sd0) && (r_w[W_TZ][31] != rz_pos));
    assign abs_tz = r_w[W_TZ][31] ? 32'(-r_w[W_TZ]) : 32'(r_w[W_TZ]);
    assign abs_rz = r_r[2][31] ? 32'(-r_r[2]) : 32'(r_r[2]);

    assign y_val = 65'(r_w[W_TY]) + 65'(p_sh);
    assign ax = r_x[64] ? -r_x : r_x;
    assign ay = y_val[64] ? -y_val : y_val;
    assign in_rect = !(ax > 65'(r_w[W_HW])) && !(ay > 65'(r_w[W_HH]));
    assign more = (32'(r_obj) + 32'd1) < 32'(lim);

    assign load_we = start && !busy && (i_operation == OP_LOAD) &&
                     (32'(i_object_slot) < 32'(MAX_OBJECTS)) &&
                     (32'(i_word_select) < 32'(WORDS_PER_ENTRY));
    assign load_addr = AW'(32'(i_object_slot) * WORDS_PER_ENTRY + 32'(i_word_select));
    assign mem_raddr = AW'(32'(r_base) + 32'(r_cnt));

    npr_table #(.DEPTH(DEPTH), .AW(AW)) u_table (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (load_addr),
        .i_wdata (i_word_value),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    npr_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    npr_div #(.NW(NW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({abs_tz, {FRAC_BITS{1'b0}}}),
        .i_divisor  (abs_rz),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_base    = r_base;
        n_obj     = r_obj;
        n_best    = r_best;
        n_found   = r_found;
        n_bd      = r_bd;
        n_d       = r_d;
        n_acc     = r_acc;
        n_x       = r_x;
        n_valid   = 1'b0;
        n_hit     = r_hit;
        n_hobj    = r_hobj;
        n_pt      = r_pt;
        n_hpar    = r_hpar;
        mul_a     = 32'sd0;
        mul_b     = 32'sd0;
        div_start = 1'b0;
        w_en      = 1'b0;
        r_en      = 1'b0;
        r_idx     = f_div3(km1);
        dir_en    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start && (i_operation == OP_RAY)) begin
                    dir_en  = 1'b1;
                    n_found = 1'b0;
                    n_obj   = '0;
                    n_base  = '0;
                    n_cnt   = 4'd0;
                    n_state = (lim == '0) ? S_POINT : S_FETCH;
                end
            end
            S_FETCH: begin
                w_en  = (r_cnt != 4'd0);
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'(WORDS_PER_ENTRY)) begin
                    n_cnt   = 4'd0;
                    n_state = S_ROT;
                end
            end
            S_ROT: begin
                if (r_cnt < 4'd9) begin
                    mul_a = r_w[r_cnt];
                    mul_b = r_dir[f_mod3(r_cnt)];
                end
                if (r_cnt != 4'd0) begin
                    n_acc = acc_sum;
                    r_en  = (f_mod3(km1) == 2'd2);
                end
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd9) begin
                    n_cnt   = 4'd0;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (reject) begin
                    n_state = more ? S_FETCH : S_POINT;
                    n_obj   = more ? r_obj + 1'b1 : r_obj;
                    n_base  = more ? AW'(32'(r_base) + WORDS_PER_ENTRY) : r_base;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (div_q[NW-1:31] != '0) begin
                        n_state = more ? S_FETCH : S_POINT;
                        n_obj   = more ? r_obj + 1'b1 : r_obj;
                        n_base  = more ? AW'(32'(r_base) + WORDS_PER_ENTRY) : r_base;
                    end else begin
                        n_d     = div_q[30:0];
                        n_state = S_PLANE;
                    end
                end
            end
            S_PLANE: begin
                mul_a = $signed({1'b0, r_d});
                mul_b = r_r[r_cnt[1:0]];
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd1) begin
                    n_x = 65'(r_w[W_TX]) + 65'(p_sh);
                end
                if (r_cnt == 4'd2) begin
                    n_cnt = 4'd0;
                    if (in_rect && (!r_found || (r_d < r_bd))) begin
                        n_found = 1'b1;
                        n_bd    = r_d;
                        n_best  = r_obj[IW-1:0];
                    end
                    n_state = more ? S_FETCH : S_POINT;
                    n_obj   = more ? r_obj + 1'b1 : r_obj;
                    n_base  = more ? AW'(32'(r_base) + WORDS_PER_ENTRY) : r_base;
                end
            end
            S_POINT: begin
                mul_a = $signed({1'b0, r_bd});
                mul_b = r_dir[r_cnt[1:0]];
                n_cnt = r_cnt + 4'd1;
                if (r_cnt != 4'd0) begin
                    n_pt[km1[1:0]] = f_sat32(66'(p_sh));
                end
                if (!r_found) begin
                    n_cnt   = 4'd0;
                    n_valid = 1'b1;
                    n_hit   = 1'b0;
                    n_hobj  = 4'd0;
                    n_pt[0] = 32'sd0;
                    n_pt[1] = 32'sd0;
                    n_pt[2] = 32'sd0;
                    n_hpar  = 31'd0;
                    n_state = S_IDLE;
                end else if (r_cnt == 4'd3) begin
                    n_cnt   = 4'd0;
                    n_valid = 1'b1;
                    n_hit   = 1'b1;
                    n_hobj  = 4'(r_best);
                    n_hpar  = r_bd;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= 4'd0;
            r_valid  <= 1'b0;
            r_found  <= 1'b0;
            r_objcnt <= 5'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
            r_found <= n_found;
            if (i_cfg_we) begin
                r_objcnt <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_obj  <= n_obj;
        r_best <= n_best;
        r_bd   <= n_bd;
        r_d    <= n_d;
        r_acc  <= n_acc;
        r_x    <= n_x;
        r_hit  <= n_hit;
        r_hobj <= n_hobj;
        r_pt   <= n_pt;
        r_hpar <= n_hpar;
        if (w_en) begin
            r_w[km1] <= mem_rdata;
        end
        if (r_en) begin
            r_r[r_idx] <= f_sat32(acc_sum >>> FRAC_BITS);
        end
        if (dir_en) begin
            r_dir[0] <= i_dir_x;
            r_dir[1] <= i_dir_y;
            r_dir[2] <= i_dir_z;
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_hit           = r_hit;
    assign o_hit_object    = r_hobj;
    assign o_point_x       = r_pt[0];
    assign o_point_y       = r_pt[1];
    assign o_point_z       = r_pt[2];
    assign o_hit_parameter = r_hpar;

    `NPR_ASSERT_SAME(a_valid_idle, o_valid, !busy, "result strobe while busy")
    `NPR_ASSERT_NEXT(a_ray_busy, start && !busy && (i_operation == OP_RAY), busy || o_valid,
        "ray transaction did not start a search")
    `NPR_ASSERT_SAME(a_miss_zero, o_valid && !o_hit,
        (o_hit_object == 4'd0) && (o_hit_parameter == 31'd0) && (o_point_x == 32'sd0),
        "miss result not cleared")
    `NPR_ASSERT_NEXT(a_load_idle, start && !busy && (i_operation == OP_LOAD), !busy,
        "load transaction made the block busy")

endmodule
`default_nettype wire

/* rtl/npr_table.sv */
`timescale 1ns / 1ps
`default_nettype none
module npr_table import npr_pkg::*; #(
    parameter int DEPTH = MAX_OBJECTS_DEF * WORDS_PER_ENTRY,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [31:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* rtl/npr_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
module npr_mul import npr_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output logic signed [63:0]      o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end

endmodule
`default_nettype wire

/* rtl/npr_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module npr_div import npr_pkg::*; #(
    parameter int NW = 32 + FRAC_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_dividend,
    input  wire logic [31:0]   i_divisor,
    output logic               o_done,
    output logic [NW-1:0]      o_quotient
);

    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [31:0]   r_rem;
    logic [31:0]   r_div;
    logic [NW-1:0] r_q;
    logic          r_done;
    logic [32:0]   rem_sh;
    logic [33:0]   diff;

    assign rem_sh = {r_rem, r_q[NW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            if (!diff[33]) begin
                r_rem <= diff[31:0];
                r_q   <= {r_q[NW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[31:0];
                r_q   <= {r_q[NW-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule
`default_nettype wire
